// ===== hdl/rstrk_pkg.sv =====
`timescale 1ns / 1ps
// Package of the roaming station tracker: table sizes, register and operation
// codes, controller states and the layouts of the table entries. No dependencies.
package rstrk_pkg;

  localparam int ACTIVE_ENTRIES   = 32;
  localparam int GONE_ENTRIES     = 32;
  localparam int RECONNECT_WINDOW = 30;
  localparam int MAX_RESULTS      = 32;

  localparam int A_CNT_W = $clog2(ACTIVE_ENTRIES + 1);
  localparam int G_CNT_W = $clog2(GONE_ENTRIES + 1);
  localparam int A_IDX_W = (ACTIVE_ENTRIES > 1) ? $clog2(ACTIVE_ENTRIES) : 1;
  localparam int G_IDX_W = (GONE_ENTRIES > 1) ? $clog2(GONE_ENTRIES) : 1;
  localparam int SCAN_W  = (A_CNT_W > G_CNT_W) ? A_CNT_W : G_CNT_W;
  localparam int RPT_W   = $clog2(MAX_RESULTS + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REPORT_INTERVAL = 2'd0,
    REG_START_ONLINE    = 2'd1,
    REG_START_RSSI      = 2'd2,
    REG_REPORT_RSSI     = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    OP_AGE    = 3'd0,
    OP_SEEN   = 3'd1,
    OP_LEFT   = 3'd2,
    OP_REPORT = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_A_RD,
    ST_A_CHK,
    ST_G_RD,
    ST_G_CHK,
    ST_RECON,
    ST_A_INS,
    ST_G_INS,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [47:0]        mac;
    logic [32:0]        expiry;
    logic signed [7:0]  rssi;
    logic [30:0]        online;
    logic               reportable;
  } act_entry_t;

  typedef struct packed {
    logic [47:0] mac;
    logic [32:0] expiry;
  } gone_entry_t;

endpackage

// ===== hdl/rstrk_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the roaming station tracker: one for the
// event words coming in and one for the result words going out.
interface rstrk_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        op;
  logic [47:0]       station_mac;
  logic [30:0]       uptime;
  logic signed [7:0] signal_level;
  logic [31:0]       now;

  modport source (output valid, op, station_mac, uptime, signal_level, now,
                  input ready);
  modport sink   (input valid, op, station_mac, uptime, signal_level, now,
                  output ready);
endinterface

interface rstrk_out_if;
  logic              valid;
  logic              ready;
  logic              status;
  logic              valid_res;
  logic [47:0]       reported_mac;
  logic [30:0]       link_time;
  logic signed [7:0] reported_rssi;
  logic              last;

  modport source (output valid, status, valid_res, reported_mac, link_time,
                  reported_rssi, last, input ready);
  modport sink   (input valid, status, valid_res, reported_mac, link_time,
                  reported_rssi, last, output ready);
endinterface

// ===== hdl/roaming_station_tracker.sv =====
`timescale 1ns / 1ps
// Roaming station tracker top level: keeps the active and departed station tables.
// Depends on rstrk_pkg and the channel interfaces in rstrk_if.sv.

// The block takes one event word at a time and answers with one result word, or
// with one word per reported station for a report. Both tables sit in memories
// with registered reads, and every operation but clear and unknown ones walks them
// entry by entry (read, then check and write back in place, which also compacts
// the table when entries are removed); a seen word for a new station walks both
// tables and then may insert. Clear and unknown operations walk no table. A report
// stalls its walk when the result register is still occupied, and every item waits
// at its end until the result register is free for the final word.
// Configuration is written through cfg_we, cfg_index and cfg_data and must only
// change while the block is idle.
module roaming_station_tracker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rstrk_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rstrk_pkg::CFG_DATA_W-1:0]  cfg_data,
  rstrk_in_if.sink                          in_ch,
  rstrk_out_if.source                       out_ch
);
  import rstrk_pkg::*;

  // Configuration registers.
  logic [23:0]       rpt_period;
  logic [30:0]       entry_uptime;
  logic signed [7:0] entry_rssi;
  logic signed [7:0] report_rssi;

  state_t state, state_next;

  // Latched event word.
  logic [2:0]        op_r;
  logic [47:0]       mac_r;
  logic [30:0]       online_r;
  logic signed [7:0] rssi_r;
  logic [31:0]       now_r;

  logic [A_CNT_W-1:0] a_cnt;
  logic [G_CNT_W-1:0] g_cnt;
  logic [SCAN_W-1:0]  scan;
  logic [SCAN_W-1:0]  wp;
  logic               afound;
  logic               gfound;
  logic               recon;
  logic               status_r;
  logic [32:0]        gexp_r;
  logic               pend_v;
  act_entry_t         pend;
  logic [RPT_W-1:0]   rpt_n;

  // Result register.
  logic              o_v;
  logic              o_status;
  logic              o_vres;
  logic [47:0]       o_mac;
  logic [30:0]       o_time;
  logic signed [7:0] o_rssi;
  logic              o_last;

  act_entry_t  act_mem [ACTIVE_ENTRIES];
  gone_entry_t gone_mem [GONE_ENTRIES];
  act_entry_t  a_rd;
  gone_entry_t g_rd;

  logic              accept;
  logic              push_ok;
  logic              o_load;
  logic              a_end;
  logic              g_end;
  logic [32:0]       exp_new;
  logic              a_mac_eq;
  logic              a_drop;
  logic              rpt_hit;
  logic              a_stall;
  logic              g_mac_eq;
  logic              g_drop;
  logic              ins_cond;
  logic              a_full;
  logic              g_full;
  logic              a_we;
  logic [A_IDX_W-1:0] a_wa;
  act_entry_t        a_wd;
  logic              g_we;
  logic [G_IDX_W-1:0] g_wa;
  gone_entry_t       g_wd;
  logic [33:0]       since_start;
  logic [33:0]       left_at;
  logic signed [34:0] gap;

  assign accept  = in_ch.valid && in_ch.ready;
  assign push_ok = !o_v || out_ch.ready;
  assign o_load  = (state == ST_A_CHK && rpt_hit && pend_v && push_ok)
                || (state == ST_FIN && push_ok);
  assign a_end   = (scan == SCAN_W'(a_cnt));
  assign g_end   = (scan == SCAN_W'(g_cnt));
  assign exp_new = {1'b0, now_r} + {8'b0, rpt_period, 1'b0};
  assign a_full  = (a_cnt == A_CNT_W'(ACTIVE_ENTRIES));
  assign g_full  = (g_cnt == G_CNT_W'(GONE_ENTRIES));
  assign ins_cond = (online_r > entry_uptime) || (rssi_r > entry_rssi) || recon;

  // Reconnection test: the station's start time against the time it left.
  assign since_start = {2'b0, now_r} - {3'b0, online_r};
  assign left_at     = {1'b0, gexp_r} - {9'b0, rpt_period, 1'b0};
  assign gap         = $signed({since_start[33], since_start})
                     - $signed({left_at[33], left_at});

  assign in_ch.ready          = (state == ST_IDLE) && !rst;
  assign out_ch.valid         = o_v;
  assign out_ch.status        = o_status;
  assign out_ch.valid_res     = o_vres;
  assign out_ch.reported_mac  = o_mac;
  assign out_ch.link_time     = o_time;
  assign out_ch.reported_rssi = o_rssi;
  assign out_ch.last          = o_last;

  // Per-entry decisions of the table walks.
  always_comb begin
    a_mac_eq = (a_rd.mac == mac_r);
    a_drop   = 1'b0;
    if (op_r == OP_AGE) begin
      a_drop = (a_rd.expiry < {1'b0, now_r});
    end else if (op_r == OP_LEFT) begin
      a_drop = a_mac_eq;
    end
    rpt_hit = (op_r == OP_REPORT) && a_rd.reportable && (a_rd.rssi < report_rssi)
           && (rpt_n < RPT_W'(MAX_RESULTS));
    a_stall = rpt_hit && pend_v && !push_ok;

    g_mac_eq = (g_rd.mac == mac_r);
    g_drop   = 1'b0;
    if (op_r == OP_AGE) begin
      g_drop = (g_rd.expiry < {1'b0, now_r});
    end else if (op_r == OP_SEEN) begin
      g_drop = g_mac_eq;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          case (in_ch.op)
            OP_AGE, OP_SEEN, OP_REPORT: state_next = ST_A_RD;
            OP_LEFT:                    state_next = ST_G_RD;
            default:                    state_next = ST_FIN;
          endcase
        end
      end
      ST_A_RD: begin
        if (a_end) begin
          case (op_r)
            OP_AGE:  state_next = ST_G_RD;
            OP_SEEN: state_next = afound ? ST_FIN : ST_G_RD;
            OP_LEFT: state_next = gfound ? ST_FIN : ST_G_INS;
            default: state_next = ST_FIN;
          endcase
        end else begin
          state_next = ST_A_CHK;
        end
      end
      ST_A_CHK: state_next = a_stall ? ST_A_CHK : ST_A_RD;
      ST_G_RD: begin
        if (g_end) begin
          case (op_r)
            OP_SEEN: state_next = ST_RECON;
            OP_LEFT: state_next = ST_A_RD;
            default: state_next = ST_FIN;
          endcase
        end else begin
          state_next = ST_G_CHK;
        end
      end
      ST_G_CHK: state_next = ST_G_RD;
      ST_RECON: state_next = ST_A_INS;
      ST_A_INS: state_next = ST_FIN;
      ST_G_INS: state_next = ST_FIN;
      ST_FIN:   state_next = push_ok ? ST_IDLE : ST_FIN;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Memory write ports.
  always_comb begin
    a_we = 1'b0;
    a_wa = wp[A_IDX_W-1:0];
    a_wd = a_rd;
    g_we = 1'b0;
    g_wa = wp[G_IDX_W-1:0];
    g_wd = g_rd;
    unique case (state)
      ST_A_CHK: begin
        a_we = !a_drop && !a_stall;
        if (op_r == OP_SEEN && a_mac_eq) begin
          a_wd.expiry = exp_new;
          a_wd.rssi   = rssi_r;
          a_wd.online = online_r;
        end
      end
      ST_A_INS: begin
        a_we            = ins_cond && !a_full;
        a_wa            = a_cnt[A_IDX_W-1:0];
        a_wd.mac        = mac_r;
        a_wd.expiry     = exp_new;
        a_wd.rssi       = rssi_r;
        a_wd.online     = online_r;
        a_wd.reportable = !recon;
      end
      ST_G_CHK: begin
        g_we = !g_drop;
        if (op_r == OP_LEFT && g_mac_eq) begin
          g_wd.expiry = exp_new;
        end
      end
      ST_G_INS: begin
        g_we        = !g_full;
        g_wa        = g_cnt[G_IDX_W-1:0];
        g_wd.mac    = mac_r;
        g_wd.expiry = exp_new;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      act_mem[a_wa] <= a_wd;
    end
    if (state == ST_A_RD && !a_end) begin
      a_rd <= act_mem[scan[A_IDX_W-1:0]];
    end
    if (g_we) begin
      gone_mem[g_wa] <= g_wd;
    end
    if (state == ST_G_RD && !g_end) begin
      g_rd <= gone_mem[scan[G_IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      rpt_period   <= 24'd30;
      entry_uptime <= '0;
      entry_rssi   <= '0;
      report_rssi  <= -8'sd70;
      a_cnt        <= '0;
      g_cnt        <= '0;
      o_v          <= 1'b0;
      pend_v       <= 1'b0;
      rpt_n        <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_REPORT_INTERVAL: rpt_period   <= cfg_data[23:0];
          REG_START_ONLINE:    entry_uptime <= cfg_data;
          REG_START_RSSI:      entry_rssi   <= cfg_data[7:0];
          REG_REPORT_RSSI:     report_rssi  <= cfg_data[7:0];
          default: begin
          end
        endcase
      end
      if (o_load) begin
        o_v <= 1'b1;
      end else if (out_ch.ready) begin
        o_v <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            op_r     <= in_ch.op;
            mac_r    <= in_ch.station_mac;
            online_r <= in_ch.uptime;
            rssi_r   <= in_ch.signal_level;
            now_r    <= in_ch.now;
            scan     <= '0;
            wp       <= '0;
            afound   <= 1'b0;
            gfound   <= 1'b0;
            recon    <= 1'b0;
            status_r <= 1'b0;
            pend_v   <= 1'b0;
            rpt_n    <= '0;
            if (in_ch.op == OP_CLEAR) begin
              a_cnt <= '0;
              g_cnt <= '0;
            end
          end
        end
        ST_A_RD: begin
          if (a_end) begin
            a_cnt <= wp[A_CNT_W-1:0];
            scan  <= '0;
            wp    <= '0;
          end
        end
        ST_A_CHK: begin
          if (!a_stall) begin
            scan <= scan + 1'b1;
            if (!a_drop) begin
              wp <= wp + 1'b1;
            end
            if (op_r == OP_SEEN && a_mac_eq) begin
              afound <= 1'b1;
            end
            // A match is held back one step so the final word can carry last.
            if (rpt_hit) begin
              if (pend_v) begin
                o_status <= 1'b0;
                o_vres   <= 1'b1;
                o_mac    <= pend.mac;
                o_time   <= pend.online;
                o_rssi   <= pend.rssi;
                o_last   <= 1'b0;
              end
              pend   <= a_rd;
              pend_v <= 1'b1;
              rpt_n  <= rpt_n + 1'b1;
            end
          end
        end
        ST_G_RD: begin
          if (g_end) begin
            g_cnt <= wp[G_CNT_W-1:0];
            scan  <= '0;
            wp    <= '0;
          end
        end
        ST_G_CHK: begin
          scan <= scan + 1'b1;
          if (!g_drop) begin
            wp <= wp + 1'b1;
          end
          if ((op_r == OP_SEEN || op_r == OP_LEFT) && g_mac_eq) begin
            gfound <= 1'b1;
            gexp_r <= g_rd.expiry;
          end
        end
        ST_RECON: begin
          recon <= gfound && !gap[34] && (gap < 35'sd1 * RECONNECT_WINDOW);
        end
        ST_A_INS: begin
          if (ins_cond) begin
            if (a_full) begin
              status_r <= 1'b1;
            end else begin
              a_cnt <= a_cnt + 1'b1;
            end
          end
        end
        ST_G_INS: begin
          if (g_full) begin
            status_r <= 1'b1;
          end else begin
            g_cnt <= g_cnt + 1'b1;
          end
        end
        ST_FIN: begin
          if (push_ok) begin
            o_last <= 1'b1;
            if (pend_v) begin
              o_status <= 1'b0;
              o_vres   <= 1'b1;
              o_mac    <= pend.mac;
              o_time   <= pend.online;
              o_rssi   <= pend.rssi;
            end else begin
              o_status <= status_r;
              o_vres   <= 1'b0;
              o_mac    <= '0;
              o_time   <= '0;
              o_rssi   <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    a_cnt <= A_CNT_W'(ACTIVE_ENTRIES))
    else $error("active count beyond table size");

  g_cnt_range: assert property (@(posedge clk) disable iff (rst)
    g_cnt <= G_CNT_W'(GONE_ENTRIES))
    else $error("gone count beyond table size");

  compact_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_A_CHK || state == ST_G_CHK) |-> wp <= scan)
    else $error("compaction write pointer ran ahead of the read index");

  rpt_cap: assert property (@(posedge clk) disable iff (rst)
    rpt_n <= RPT_W'(MAX_RESULTS))
    else $error("report emitted more words than allowed");

  fin_word: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && push_ok) |=> (o_v && o_last && state == ST_IDLE))
    else $error("final word not issued when leaving the operation");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Testbench of roaming_station_tracker: random and directed station events with a
// table predictor in the bench, checked word by word. Uses rstrk_pkg and rstrk_if.sv.
module tb;
  import rstrk_pkg::*;

  typedef struct {
    logic [2:0]        op;
    logic [47:0]       mac;
    logic [30:0]       online;
    logic signed [7:0] rssi;
    logic [31:0]       now;
  } event_t;

  typedef struct {
    logic              status;
    logic              valid_res;
    logic [47:0]       mac;
    logic [30:0]       ct;
    logic signed [7:0] rssi;
    logic              last;
  } result_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rstrk_in_if  in_ch ();
  rstrk_out_if out_ch ();

  roaming_station_tracker dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
  );

  // Predicted tables, kept compacted like the block keeps them.
  logic [23:0]        m_interval;
  logic [30:0]        m_start_online;
  logic signed [7:0]  m_start_rssi;
  logic signed [7:0]  m_report_rssi;
  int                 act_n, gone_n;
  logic [47:0]        act_mac [ACTIVE_ENTRIES];
  logic [32:0]        act_exp [ACTIVE_ENTRIES];
  logic signed [7:0]  act_rssi [ACTIVE_ENTRIES];
  logic [30:0]        act_online [ACTIVE_ENTRIES];
  logic               act_rep [ACTIVE_ENTRIES];
  logic [47:0]        gone_mac [GONE_ENTRIES];
  logic [32:0]        gone_exp [GONE_ENTRIES];

  event_t  pend_events [$];
  result_t expected_results [$];
  int      errors;
  int      idle_pct;
  int      hold_asks, hold_seen, hold_left;
  int      quiet_cycles;

  logic [47:0] macs [48];
  logic [31:0] left_time [48];
  logic [31:0] cur_now;

  function automatic logic [32:0] expiry_at(logic [31:0] t);
    logic [63:0] s;
    s = {32'd0, t} + 64'(2 * m_interval);
    return s[32:0];
  endfunction

  function automatic void act_remove(int k);
    for (int i = k; i + 1 < act_n; i++) begin
      act_mac[i] = act_mac[i+1];
      act_exp[i] = act_exp[i+1];
      act_rssi[i] = act_rssi[i+1];
      act_online[i] = act_online[i+1];
      act_rep[i] = act_rep[i+1];
    end
    act_n--;
  endfunction

  function automatic void gone_remove(int k);
    for (int i = k; i + 1 < gone_n; i++) begin
      gone_mac[i] = gone_mac[i+1];
      gone_exp[i] = gone_exp[i+1];
    end
    gone_n--;
  endfunction

  function automatic int act_find(logic [47:0] mac);
    for (int i = 0; i < act_n; i++) if (act_mac[i] == mac) return i;
    return -1;
  endfunction

  function automatic int gone_find(logic [47:0] mac);
    for (int i = 0; i < gone_n; i++) if (gone_mac[i] == mac) return i;
    return -1;
  endfunction

  // Updates the tables for one accepted event word and queues its result words.
  function automatic void track_event(event_t ev);
    result_t r;
    logic status;
    int k, g, i, cnt;
    logic recon;
    logic [63:0] left_at, diff;
    status = 0;
    cnt = 0;
    case (ev.op)
      OP_AGE: begin
        i = 0;
        while (i < act_n) if (act_exp[i] < {1'b0, ev.now}) act_remove(i); else i++;
        i = 0;
        while (i < gone_n) if (gone_exp[i] < {1'b0, ev.now}) gone_remove(i); else i++;
      end
      OP_SEEN: begin
        k = act_find(ev.mac);
        if (k >= 0) begin
          act_exp[k] = expiry_at(ev.now);
          act_rssi[k] = ev.rssi;
          act_online[k] = ev.online;
        end else begin
          recon = 0;
          g = gone_find(ev.mac);
          if (g >= 0) begin
            left_at = {31'd0, gone_exp[g]} - 64'(2 * m_interval);
            diff = ({32'd0, ev.now} - {33'd0, ev.online}) - left_at;
            recon = diff < 64'(RECONNECT_WINDOW);
            gone_remove(g);
          end
          if (ev.online > m_start_online || ev.rssi > m_start_rssi || recon) begin
            if (act_n >= ACTIVE_ENTRIES) status = 1;
            else begin
              act_mac[act_n] = ev.mac;
              act_exp[act_n] = expiry_at(ev.now);
              act_rssi[act_n] = ev.rssi;
              act_online[act_n] = ev.online;
              act_rep[act_n] = !recon;
              act_n++;
            end
          end
        end
      end
      OP_LEFT: begin
        g = gone_find(ev.mac);
        if (g >= 0) gone_exp[g] = expiry_at(ev.now);
        k = act_find(ev.mac);
        if (k >= 0) act_remove(k);
        if (g < 0) begin
          if (gone_n >= GONE_ENTRIES) status = 1;
          else begin
            gone_mac[gone_n] = ev.mac;
            gone_exp[gone_n] = expiry_at(ev.now);
            gone_n++;
          end
        end
      end
      OP_REPORT: begin
        for (i = 0; i < act_n && cnt < MAX_RESULTS; i++) begin
          if (act_rep[i] && act_rssi[i] < m_report_rssi) begin
            r = '{0, 1, act_mac[i], act_online[i], act_rssi[i], 0};
            expected_results.push_back(r);
            cnt++;
          end
        end
      end
      OP_CLEAR: begin
        act_n = 0;
        gone_n = 0;
      end
      default: ;
    endcase
    if (cnt == 0) begin
      r = '{status, 0, 0, 0, 0, 1};
      expected_results.push_back(r);
    end else begin
      expected_results[expected_results.size()-1].last = 1;
    end
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Event driver.
  always @(posedge clk) begin
    event_t ev;
    if (rst) begin
      in_ch.valid <= 0;
      in_ch.op <= OP_AGE;
      in_ch.station_mac <= 0;
      in_ch.uptime <= 0;
      in_ch.signal_level <= 0;
      in_ch.now <= 0;
      act_n = 0;
      gone_n = 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        ev = '{in_ch.op, in_ch.station_mac, in_ch.uptime, in_ch.signal_level,
               in_ch.now};
        track_event(ev);
      end
      if (pend_events.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        ev = pend_events.pop_front();
        in_ch.op <= ev.op;
        in_ch.station_mac <= ev.mac;
        in_ch.uptime <= ev.online;
        in_ch.signal_level <= ev.rssi;
        in_ch.now <= ev.now;
        in_ch.valid <= 1;
      end else begin
        in_ch.valid <= 0;
      end
    end
  end

  // Result monitor, with the long hold-off counted here.
  always @(posedge clk) begin
    result_t got, want;
    if (rst) begin
      out_ch.ready <= 0;
      errors = 0;
      hold_seen = 0;
      hold_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.status, out_ch.valid_res, out_ch.reported_mac,
                out_ch.link_time, out_ch.reported_rssi, out_ch.last};
        if (expected_results.size() == 0) begin
          if (errors < 10) $display("Unexpected result word: %p", got);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.valid_res !== want.valid_res ||
              got.mac !== want.mac || got.ct !== want.ct ||
              got.rssi !== want.rssi || got.last !== want.last) begin
            if (errors < 10) $display("Mismatch: expected %p, got %p", want, got);
            errors++;
          end
        end
      end
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic void add_event(logic [2:0] op, logic [47:0] mac, logic [30:0] online,
                                    logic signed [7:0] rssi, logic [31:0] now);
    event_t ev;
    ev = '{op, mac, online, rssi, now};
    pend_events.push_back(ev);
  endfunction

  task automatic drain();
    while (pend_events.size() > 0 || in_ch.valid) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [30:0] value);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      REG_REPORT_INTERVAL: m_interval = value[23:0];
      REG_START_ONLINE:    m_start_online = value;
      REG_START_RSSI:      m_start_rssi = value[7:0];
      default:             m_report_rssi = value[7:0];
    endcase
  endtask

  // Mostly seen and left words on a small station pool so that the tables fill,
  // refresh, age out and reconnect; the rest are reports, ages, clears and odd words.
  task automatic queue_random(int count);
    int sel, idx;
    logic [30:0] online;
    for (int n = 0; n < count; n++) begin
      cur_now += $urandom_range(0, 8);
      idx = $urandom_range(0, 47);
      sel = $urandom_range(0, 99);
      if ($urandom_range(0, 2) == 0)
        online = 31'(cur_now - left_time[idx] - $urandom_range(0, 35));
      else if ($urandom_range(0, 3) == 0) online = 31'($urandom);
      else online = 31'($urandom_range(0, 200));
      if (sel < 45) begin
        add_event(OP_SEEN, macs[idx], online, 8'($urandom), cur_now);
      end else if (sel < 65) begin
        left_time[idx] = cur_now;
        add_event(OP_LEFT, macs[idx], 31'($urandom), 8'($urandom), cur_now);
      end else if (sel < 78) begin
        add_event(OP_REPORT, 48'({$urandom, $urandom}), 31'($urandom), 8'($urandom),
                  cur_now);
      end else if (sel < 92) begin
        add_event(OP_AGE, 48'({$urandom, $urandom}), 31'($urandom), 8'($urandom),
                  cur_now);
      end else if (sel < 95) begin
        add_event(OP_CLEAR, 48'({$urandom, $urandom}), 31'($urandom), 8'($urandom),
                  cur_now);
      end else begin
        add_event(3'($urandom_range(5, 7)), 48'({$urandom, $urandom}), 31'($urandom),
                  8'($urandom), cur_now);
      end
    end
  endtask

  // Fills both tables past their size to hit the full flag.
  task automatic queue_fill();
    for (int i = 0; i < 36; i++)
      add_event(OP_SEEN, {16'hF00D, 32'(i)}, 31'd5000, 8'sd100, cur_now);
    add_event(OP_REPORT, 0, 0, 0, cur_now);
    for (int i = 0; i < 36; i++)
      add_event(OP_LEFT, {16'hBEEF, 32'(i)}, 0, 0, cur_now);
    add_event(OP_CLEAR, 0, 0, 0, cur_now);
  endtask

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_index = REG_REPORT_INTERVAL;
    cfg_data = 0;
    idle_pct = 35;
    hold_asks = 0;
    m_interval = 30;
    m_start_online = 0;
    m_start_rssi = 0;
    m_report_rssi = -70;
    cur_now = 1000;
    for (int i = 0; i < 48; i++) begin
      macs[i] = 48'({$urandom, $urandom});
      left_time[i] = 0;
    end
    macs[0] = '0;
    macs[1] = '1;
    repeat (11) @(posedge clk);
    rst <= 0;

    // Directed words: field extremes, every op, reconnection and empty report.
    add_event(OP_AGE, 0, 0, 0, 0);
    add_event(OP_SEEN, '0, 0, -8'sd128, 10);
    add_event(OP_SEEN, '1, '1, 8'sd127, 10);
    add_event(OP_SEEN, '1, 31'd7, -8'sd90, 12);
    add_event(OP_SEEN, 48'h123456789ABC, 31'd5, -8'sd100, 15);
    add_event(OP_REPORT, 0, 0, 0, 16);
    add_event(OP_LEFT, 48'h123456789ABC, 0, 0, 20);
    add_event(OP_SEEN, 48'h123456789ABC, 31'd30, -8'sd100, 50);
    add_event(OP_REPORT, 0, 0, 0, 51);
    add_event(OP_LEFT, 48'hA5A5A5A5A5A5, 0, 0, 52);
    add_event(OP_LEFT, 48'hA5A5A5A5A5A5, 0, 0, 60);
    add_event(OP_SEEN, 48'hA5A5A5A5A5A5, 31'd500, -8'sd5, 200);
    add_event(OP_AGE, 0, 0, 0, 110);
    add_event(OP_REPORT, 0, 0, 0, 111);
    add_event(3'd5, '1, '1, -8'sd1, '1);
    add_event(3'd6, 0, 0, 0, 0);
    add_event(3'd7, '1, 0, 0, 0);
    add_event(OP_SEEN, 48'h5A5A5A5A5A5A, 31'd1, 8'sd1, '1);
    add_event(OP_AGE, 0, 0, 0, '1);
    add_event(OP_CLEAR, 0, 0, 0, '1);
    add_event(OP_REPORT, 0, 0, 0, '1);
    drain();

    write_reg(REG_REPORT_INTERVAL, 0);
    write_reg(REG_START_ONLINE, 31'h7FFF_FFFF);
    write_reg(REG_START_RSSI, 31'(8'sd127));
    write_reg(REG_REPORT_RSSI, 31'(8'sd127));
    queue_random(60);
    hold_asks++;
    drain();

    write_reg(REG_REPORT_INTERVAL, 31'h00FF_FFFF);
    write_reg(REG_START_ONLINE, 0);
    write_reg(REG_START_RSSI, 31'(8'h80));
    write_reg(REG_REPORT_RSSI, 31'(8'h80));
    queue_fill();
    queue_random(60);
    drain();

    // A stretch with no idling on either side.
    write_reg(REG_REPORT_INTERVAL, 30);
    write_reg(REG_START_ONLINE, 100);
    write_reg(REG_START_RSSI, 31'(8'hC4));
    write_reg(REG_REPORT_RSSI, 31'(8'sd20));
    idle_pct = 0;
    queue_random(60);
    drain();

    idle_pct = 35;
    write_reg(REG_REPORT_INTERVAL, 12);
    write_reg(REG_START_ONLINE, 20);
    write_reg(REG_START_RSSI, 31'(8'hE2));
    write_reg(REG_REPORT_RSSI, 31'(8'hBA));
    queue_fill();
    queue_random(60);
    hold_asks++;
    drain();

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
